>>> rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic timer scheduler
// Operation codes, status codes, field widths, the cell bus structs and the
// scheduler state type.
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;
	localparam int TIMER_SLOTS = 32;
	localparam int SLOT_W = $clog2(TIMER_SLOTS);
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam int MAX_RESULTS = 32;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [7:0] ADDR_TPS = 8'd0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_REMOVE,
		S_SCAN,
		S_FIRE,
		S_OUT
	} state_t;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic        arm;
		logic        free_sel;
		logic        mark;
		logic        fire;
		logic [SLOT_W-1:0] sel;
		logic [31:0] now;
		logic [31:0] deadline;
		logic [31:0] rearm;
		logic [15:0] period;
		logic [15:0] total;
		logic [31:0] serial;
		logic [31:0] rid;
	} cell_cmd_t;

	// per-cell status toward the controller
	typedef struct packed {
		logic        used;
		logic        pending;
		logic        match;
		logic [31:0] deadline;
		logic [31:0] serial;
		logic [15:0] period;
		logic        expire;
	} cell_stat_t;

	// running earliest-pending candidate passed along the chain
	typedef struct packed {
		logic        valid;
		logic [SLOT_W-1:0] idx;
		logic [31:0] deadline;
	} cand_t;
endpackage
`default_nettype wire

>>> rtl/core/pts_cell.sv
// ----------------------------------------------------------------------------
// pts_cell: one timer slot
// Holds one timer, flags due timers at tick start and forwards the earliest
// pending candidate to its neighbor through a register.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_cell
	import pts_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [SLOT_W-1:0] idx,
	input  wire cell_cmd_t       cmd,
	input  wire cand_t           cand_in,
	output cand_t                cand_out,
	output cell_stat_t           stat
);
	logic        used_q;
	logic        pend_q;
	logic [31:0] deadline_q;
	logic [15:0] period_q;
	logic [15:0] total_q;
	logic [15:0] done_q;
	logic [31:0] serial_q;
	logic        hit;
	logic [15:0] done_nx;
	cand_t       cand_nx;
	cand_t       cand_q;

	assign hit = cmd.sel == idx;
	assign done_nx = done_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.mark)
				pend_q <= used_q && (deadline_q <= cmd.now);
			if (cmd.arm && hit)
				used_q <= 1'b1;
			if (cmd.free_sel && hit)
				used_q <= 1'b0;
			if (cmd.fire && hit) begin
				pend_q <= 1'b0;
				if (stat.expire)
					used_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.arm && hit) begin
			deadline_q <= cmd.deadline;
			period_q <= cmd.period;
			total_q <= cmd.total;
			done_q <= 16'd0;
			serial_q <= cmd.serial;
		end
		if (cmd.fire && hit) begin
			if (total_q != 16'd0)
				done_q <= done_nx;
			deadline_q <= cmd.rearm;
		end
	end

	always_comb begin
		cand_nx = cand_in;
		if (pend_q && (!cand_in.valid || deadline_q < cand_in.deadline)) begin
			cand_nx.valid = 1'b1;
			cand_nx.idx = idx;
			cand_nx.deadline = deadline_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q <= cand_nx;
		end
	end

	assign cand_out = cand_q;

	assign stat.used = used_q;
	assign stat.pending = pend_q;
	assign stat.match = used_q && (serial_q == cmd.rid);
	assign stat.deadline = deadline_q;
	assign stat.serial = serial_q;
	assign stat.period = period_q;
	assign stat.expire = (total_q != 16'd0) && (done_nx >= total_q);
endmodule
`default_nettype wire

>>> rtl/core/periodic_timer_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_timer_scheduler: slot-based periodic timer table
// Controller plus a chain of slot cells; adds, removes and fires timers.
// ----------------------------------------------------------------------------
// Use: commands enter on the s_axis channel (func, now, repeat_total,
// period_seconds, fire_soon, first_delay_seconds, remove_id). Results leave
// on m_axis; tlast marks the final result of one command.
// Add: multiply seconds by ticks_per_second in S_MUL, then arm the lowest
// free slot and register the result in S_ADD.
// Remove: the matching slot is freed and the result registered in S_REMOVE.
// Tick: the due slots are marked at acceptance. The earliest candidate moves
// one cell per cycle along the registered chain; each search waits in S_SCAN
// until the candidate has passed every cell, and a firing re-arms its slot in
// S_FIRE. Fired results trail one search behind.
// One command is in work at a time; s_axis_tready is low while busy.
// The result register holds its item while m_axis_tready is low and the
// block waits. Reset empties all slots, sets the next id to one and
// ticks_per_second to 1000. ticks_per_second is written over APB at 0x0.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_timer_scheduler
	import pts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: now[31:0], repeat_total[47:32], period_seconds[63:48],
	// fire_soon[64], first_delay_seconds[80:65], remove_id[112:81]
	input  wire logic [119:0] s_axis_tdata,
	// tuser: func[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: timer_id[31:0], fired[32], status[34:33]
	output logic [39:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	state_t      state_q, state_nx;
	logic [19:0] tps_q;
	logic [31:0] next_serial_q;
	logic [31:0] now_q;
	logic [15:0] total_q;
	logic [15:0] period_q;
	logic [15:0] secs_q;
	logic [31:0] rid_q;
	logic [35:0] span_q;
	logic [SLOT_W-1:0] sel_q;
	logic [CNT_W:0] count_q;
	logic [CNT_W-1:0] settle_q;
	logic        out_v_q;
	logic [31:0] out_id_q;
	logic        out_fired_q;
	logic [1:0]  out_status_q;
	logic        out_last_q;
	logic        stg_v_q;
	logic [31:0] stg_id_q;

	cell_cmd_t   cmd;
	cell_stat_t  stat [TIMER_SLOTS];
	cand_t       chain [TIMER_SLOTS+1];

	logic        free_found;
	logic [SLOT_W-1:0] free_idx;
	logic        rm_found;
	logic [SLOT_W-1:0] rm_idx;
	logic [15:0] mul_secs;
	logic [15:0] pick_period;
	logic        in_acc;
	logic        out_free;
	logic        settled;
	logic        fire_go;

	assign pready = 1'b1;
	assign prdata = {12'd0, tps_q};
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_v_q || m_axis_tready;
	assign s_axis_tready = state_q == S_IDLE;
	assign settled = settle_q == CNT_W'(TIMER_SLOTS);
	assign fire_go = chain[TIMER_SLOTS].valid && count_q < (CNT_W+1)'(MAX_RESULTS);

	assign chain[0] = '0;
	for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
		pts_cell u_cell (
			.clk(clk), .arst_n(arst_n), .idx(SLOT_W'(g)), .cmd(cmd),
			.cand_in(chain[g]), .cand_out(chain[g+1]), .stat(stat[g])
		);
	end

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		rm_found = 1'b0;
		rm_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!stat[i].used) begin
				free_found = 1'b1;
				free_idx = SLOT_W'(i);
			end
			if (stat[i].match) begin
				rm_found = 1'b1;
				rm_idx = SLOT_W'(i);
			end
		end
	end

	assign pick_period = stat[chain[TIMER_SLOTS].idx].period;
	assign mul_secs = (state_q == S_SCAN) ? pick_period : secs_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:
				if (in_acc) begin
					case (s_axis_tuser)
						FUNC_ADD:    state_nx = S_MUL;
						FUNC_REMOVE: state_nx = S_REMOVE;
						FUNC_TICK:   state_nx = S_SCAN;
						default:     state_nx = S_IDLE;
					endcase
				end
			S_MUL:    state_nx = S_ADD;
			S_ADD:    if (out_free) state_nx = S_OUT;
			S_REMOVE: if (out_free) state_nx = S_OUT;
			S_SCAN: begin
				if (settled && out_free) begin
					if (fire_go)
						state_nx = S_FIRE;
					else
						state_nx = S_OUT;
				end
			end
			S_FIRE:   state_nx = S_SCAN;
			S_OUT:    if (out_free) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		cmd.now = now_q;
		cmd.rid = rid_q;
		cmd.deadline = now_q + span_q[31:0];
		cmd.rearm = now_q + span_q[31:0];
		cmd.period = period_q;
		cmd.total = total_q;
		cmd.serial = next_serial_q;
		case (state_q)
			S_ADD: begin
				cmd.sel = free_idx;
				cmd.arm = free_found && out_free;
			end
			S_REMOVE: begin
				cmd.sel = rm_idx;
				cmd.free_sel = rm_found && out_free;
			end
			S_FIRE:  cmd.fire = 1'b1;
			default: cmd.mark = (state_q == S_IDLE) && in_acc && s_axis_tuser == FUNC_TICK;
		endcase
		if (state_q == S_IDLE)
			cmd.now = s_axis_tdata[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tps_q <= 20'd1000;
			next_serial_q <= 32'd1;
			out_v_q <= 1'b0;
			settle_q <= '0;
		end else begin
			state_q <= state_nx;
			if (psel && penable && pwrite && paddr == ADDR_TPS[2:0])
				tps_q <= pwdata[19:0];
			if (out_v_q && m_axis_tready)
				out_v_q <= 1'b0;
			if (state_q != S_SCAN)
				settle_q <= '0;
			else if (!settled)
				settle_q <= settle_q + CNT_W'(1);
			case (state_q)
				S_ADD: if (out_free) begin
					out_v_q <= 1'b1;
					out_last_q <= 1'b1;
					out_fired_q <= 1'b0;
					if (free_found) begin
						out_id_q <= next_serial_q;
						out_status_q <= ST_OK;
						next_serial_q <= next_serial_q + 32'd1;
					end else begin
						out_id_q <= 32'd0;
						out_status_q <= ST_FULL;
					end
				end
				S_REMOVE: if (out_free) begin
					out_v_q <= 1'b1;
					out_last_q <= 1'b1;
					out_fired_q <= 1'b0;
					out_id_q <= rid_q;
					out_status_q <= rm_found ? ST_OK : ST_NOT_FOUND;
				end
				S_SCAN: if (settled && out_free) begin
					if (fire_go) begin
						sel_q <= chain[TIMER_SLOTS].idx;
						if (stg_v_q) begin
							out_v_q <= 1'b1;
							out_id_q <= stg_id_q;
							out_fired_q <= 1'b1;
							out_status_q <= ST_OK;
							out_last_q <= 1'b0;
						end
					end else if (count_q == '0) begin
						out_v_q <= 1'b1;
						out_id_q <= 32'd0;
						out_fired_q <= 1'b0;
						out_status_q <= ST_OK;
						out_last_q <= 1'b1;
					end else begin
						out_v_q <= 1'b1;
						out_id_q <= stg_id_q;
						out_fired_q <= 1'b1;
						out_status_q <= ST_OK;
						out_last_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q <= s_axis_tdata[31:0];
			total_q <= s_axis_tdata[47:32];
			period_q <= s_axis_tdata[63:48];
			secs_q <= s_axis_tdata[64] ? s_axis_tdata[80:65] : s_axis_tdata[63:48];
			rid_q <= s_axis_tdata[112:81];
		end
		if (state_q == S_MUL || (state_q == S_SCAN && state_nx == S_FIRE))
			span_q <= 36'(mul_secs) * 36'(tps_q);
	end

	// hold each fired result back one search so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_v_q <= 1'b0;
		end else begin
			if (in_acc)
				stg_v_q <= 1'b0;
			if (state_q == S_SCAN && state_nx == S_FIRE) begin
				stg_v_q <= 1'b1;
				stg_id_q <= stat[chain[TIMER_SLOTS].idx].serial;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_FIRE) begin
			count_q <= count_q + (CNT_W+1)'(1);
		end else if (in_acc) begin
			count_q <= '0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {5'd0, out_status_q, out_fired_q, out_id_q};
	assign m_axis_tlast = out_last_q;
endmodule
`default_nettype wire

>>> tb/sv/periodic_timer_scheduler_tb.sv
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_tb: self-checking bench of the timer scheduler
// Drives add, remove, tick and undefined-code items on the input stream and rewrites
// ticks_per_second over APB between phases. A predictor keeps its own copy
// of the slot table and queues the expected results of every accepted item.
// Each output item is checked field by field against the oldest one. A
// directed table comes first, then a burst that fills the table, then
// random traffic under several tick rates. Both sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_timer_scheduler_tb
	import pts_pkg::*;
;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] now;
		logic [15:0] total;
		logic [15:0] period;
		logic        soon;
		logic [15:0] delay;
		logic [31:0] rid;
	} cmd_t;

	typedef struct {
		logic [31:0] id;
		logic        fired;
		logic [1:0]  status;
		logic        last;
	} res_t;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t r;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [39:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// predictor copy of the block state
	logic [19:0]  tps;
	logic         tm_used [TIMER_SLOTS];
	logic [31:0]  tm_deadline [TIMER_SLOTS];
	logic [15:0]  tm_period [TIMER_SLOTS];
	logic [15:0]  tm_total [TIMER_SLOTS];
	logic [15:0]  tm_done [TIMER_SLOTS];
	logic [31:0]  tm_serial [TIMER_SLOTS];
	logic [31:0]  serial_next;

	res_t         pending_results [$];
	row_t         dir_tab [$];
	int           errors = 0;
	int           cycle_cnt = 0;
	int           idle_pct = 11;
	logic [31:0]  sim_now = 0;

	periodic_timer_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic logic [31:0] deadline_of(input logic [31:0] now, input logic [15:0] secs);
		logic [63:0] span;
		span = 64'(secs) * 64'(tps);
		return now + span[31:0];
	endfunction

	function automatic void reset_table();
		tps = 20'd1000;
		serial_next = 32'd1;
		for (int i = 0; i < TIMER_SLOTS; i++) tm_used[i] = 1'b0;
	endfunction

	function automatic void push_res(input logic [31:0] id, input logic fired,
			input logic [1:0] st, input logic last);
		res_t r;
		r.id = id; r.fired = fired; r.status = st; r.last = last;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_results(input cmd_t c);
		int slot;
		int best;
		int cnt;
		bit due [TIMER_SLOTS];
		slot = -1;
		case (c.func)
			FUNC_ADD: begin
				for (int i = TIMER_SLOTS - 1; i >= 0; i--) if (!tm_used[i]) slot = i;
				if (slot < 0) begin
					push_res(32'd0, 1'b0, ST_FULL, 1'b1);
				end else begin
					tm_used[slot] = 1'b1;
					tm_period[slot] = c.period;
					tm_total[slot] = c.total;
					tm_done[slot] = 16'd0;
					tm_serial[slot] = serial_next;
					tm_deadline[slot] = deadline_of(c.now, c.soon ? c.delay : c.period);
					serial_next = serial_next + 32'd1;
					push_res(tm_serial[slot], 1'b0, ST_OK, 1'b1);
				end
			end
			FUNC_REMOVE: begin
				for (int i = TIMER_SLOTS - 1; i >= 0; i--)
					if (tm_used[i] && tm_serial[i] == c.rid) slot = i;
				if (slot >= 0) tm_used[slot] = 1'b0;
				push_res(c.rid, 1'b0, slot >= 0 ? ST_OK : ST_NOT_FOUND, 1'b1);
			end
			FUNC_TICK: begin
				for (int i = 0; i < TIMER_SLOTS; i++)
					due[i] = tm_used[i] && tm_deadline[i] <= c.now;
				cnt = 0;
				while (cnt < MAX_RESULTS) begin
					best = -1;
					for (int i = 0; i < TIMER_SLOTS; i++)
						if (due[i] && (best < 0 || tm_deadline[i] < tm_deadline[best])) best = i;
					if (best < 0) break;
					due[best] = 0;
					push_res(tm_serial[best], 1'b1, ST_OK, 1'b0);
					cnt++;
					if (tm_total[best] != 0) tm_done[best] = tm_done[best] + 16'd1;
					if (tm_total[best] != 0 && tm_done[best] >= tm_total[best])
						tm_used[best] = 1'b0;
					else
						tm_deadline[best] = deadline_of(c.now, tm_period[best]);
				end
				if (cnt == 0) push_res(32'd0, 1'b0, ST_OK, 1'b1);
				else pending_results[pending_results.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input cmd_t c, input bit typed, input res_t r);
		int n;
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= c.func;
		s_axis_tdata <= {7'd0, c.rid, c.delay, c.soon, c.period, c.total, c.now};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		n = pending_results.size();
		predict_results(c);
		if (typed) begin
			while (pending_results.size() > n)
				pending_results.delete(pending_results.size() - 1);
			pending_results.push_back(r);
		end
		@(negedge clk);
	endtask

	task automatic write_tps(input logic [19:0] value);
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (20) @(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_TPS[2:0]; pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tps = value;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		int k;
		int pick;
		k = $urandom_range(99);
		c.func = k < 40 ? FUNC_ADD : k < 55 ? FUNC_REMOVE : k < 95 ? FUNC_TICK : 2'd3;
		c.now = $urandom;
		c.total = $urandom_range(99) < 70 ? 16'($urandom_range(0, 3)) : 16'($urandom);
		c.period = $urandom_range(99) < 80 ? 16'($urandom_range(0, 3)) : 16'($urandom);
		c.soon = $urandom_range(1);
		c.delay = $urandom_range(99) < 80 ? 16'($urandom_range(0, 3)) : 16'($urandom);
		c.rid = $urandom;
		if (c.func == FUNC_TICK) begin
			if ($urandom_range(99) < 5) sim_now = $urandom;
			else sim_now = sim_now + 32'($urandom_range(0, 4)) * 32'(tps)
				+ 32'($urandom_range(0, tps));
		end
		if (c.func == FUNC_ADD || c.func == FUNC_TICK) c.now = sim_now;
		if (c.func == FUNC_REMOVE && $urandom_range(99) < 70) begin
			pick = $urandom_range(TIMER_SLOTS - 1);
			if (tm_used[pick]) c.rid = tm_serial[pick];
		end
		return c;
	endfunction

	function automatic row_t mk_row(input logic [1:0] func, input logic [31:0] now,
			input logic [15:0] total, input logic [15:0] period, input logic soon,
			input logic [15:0] delay, input logic [31:0] rid, input bit typed,
			input logic [31:0] id, input logic [1:0] st);
		row_t w;
		w.c.func = func; w.c.now = now; w.c.total = total; w.c.period = period;
		w.c.soon = soon; w.c.delay = delay; w.c.rid = rid;
		w.typed = typed;
		w.r.id = id; w.r.fired = 1'b0; w.r.status = st; w.r.last = 1'b1;
		return w;
	endfunction

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= idle_pct);

	always @(posedge clk) begin : check_out
		res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected item id %h", m_axis_tdata[31:0]));
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== e.id || m_axis_tdata[32] !== e.fired ||
						m_axis_tdata[34:33] !== e.status || m_axis_tlast !== e.last)
					report_mismatch($sformatf("got id %h f%b st%0d l%b, want id %h f%b st%0d l%b",
						m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[34:33],
						m_axis_tlast, e.id, e.fired, e.status, e.last));
			end
		end
	end

	initial begin : stimulus
		cmd_t c;
		res_t none;
		int n;
		logic [19:0] rates [4];
		none = '{default: '0};
		reset_table();
		rates = '{20'd1, 20'd1000000, 20'd0, 20'd37};

		dir_tab.push_back(mk_row(FUNC_TICK, 32'd0, 0, 0, 0, 0, 0, 1, 32'd0, ST_OK));
		dir_tab.push_back(mk_row(FUNC_REMOVE, 32'd0, 0, 0, 0, 0, 32'd5, 1, 32'd5, ST_NOT_FOUND));
		dir_tab.push_back(mk_row(FUNC_ADD, 32'd0, 16'd1, 16'd1, 0, 0, 0, 1, 32'd1, ST_OK));
		dir_tab.push_back(mk_row(FUNC_ADD, 32'd0, 16'd0, 16'hFFFF, 1, 16'd0, 32'hFFFFFFFF,
			1, 32'd2, ST_OK));
		dir_tab.push_back(mk_row(FUNC_ADD, 32'hFFFFFFFF, 16'hFFFF, 16'd1, 0, 16'hFFFF, 0,
			1, 32'd3, ST_OK));
		dir_tab.push_back(mk_row(FUNC_ADD, 32'd500, 16'd2, 16'd3, 1, 16'hFFFF, 0, 1, 32'd4, ST_OK));
		dir_tab.push_back(mk_row(FUNC_TICK, 32'd0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
		dir_tab.push_back(mk_row(FUNC_TICK, 32'd1000, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF,
			32'hFFFFFFFF, 0, 0, ST_OK));
		dir_tab.push_back(mk_row(FUNC_TICK, 32'd4000, 0, 0, 0, 0, 0, 0, 0, ST_OK));
		dir_tab.push_back(mk_row(FUNC_REMOVE, 32'd0, 0, 0, 0, 0, 32'd2, 1, 32'd2, ST_OK));
		dir_tab.push_back(mk_row(FUNC_REMOVE, 32'd0, 0, 0, 0, 0, 32'd2, 1, 32'd2, ST_NOT_FOUND));
		dir_tab.push_back(mk_row(FUNC_REMOVE, 32'd0, 0, 0, 0, 0, 32'hFFFFFFFF, 1,
			32'hFFFFFFFF, ST_NOT_FOUND));
		dir_tab.push_back(mk_row(2'd3, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF,
			32'hFFFFFFFF, 0, 0, ST_OK));
		dir_tab.push_back(mk_row(FUNC_TICK, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, ST_OK));
		dir_tab.push_back(mk_row(FUNC_TICK, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, ST_OK));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) send_item(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);

		// fill the table past full with one-shot timers, then fire them all at once
		idle_pct = 0;
		sim_now = 32'd100000;
		for (int i = 0; i < TIMER_SLOTS + 2; i++) begin
			c = '{FUNC_ADD, sim_now, 16'd1, 16'd100, 1'b0, 16'd0, 32'($urandom)};
			send_item(c, 0, none);
		end
		sim_now = sim_now + 32'd200000;
		c = '{FUNC_TICK, sim_now, 16'd0, 16'd0, 1'b0, 16'd0, 32'd0};
		send_item(c, 0, none);
		idle_pct = 11;

		foreach (rates[p]) begin
			write_tps(rates[p]);
			n = 0;
			while (n < 25) begin
				c = random_cmd();
				if (c.func != 2'd3) n++;
				send_item(c, 0, none);
			end
		end

		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (50) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
